@@ design/ddo_pkg.sv @@
// Shared constants, types and tables for the differential drive odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS  = 24;
    localparam int FRACTION_BITS = 16;

    localparam logic [63:0] NS_PER_S        = 64'd1000000000;
    localparam logic [63:0] BAM_PER_RAD_Q48 = 64'd44798133900177;
    localparam logic [63:0] TWO_PI_Q29      = 64'd3373259426;
    localparam logic [63:0] RATE_SCALE      = 64'd105414357066578273;
    localparam logic [63:0] SINC_LIMIT      = 64'd67108864;
    localparam logic [63:0] SINC_ONE_Q32    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] DIV_BY_SIX      = 64'd6;
    localparam logic [63:0] DIV_BY_120      = 64'd120;
    localparam int          BAM_SHIFT       = 16;
    localparam int          RATE_SHIFT      = 56 - FRACTION_BITS;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic start;
        logic divide;
    } md_ctrl_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ design/ddo_muldiv.sv @@
// Digit-serial multiply (4 bits per cycle) with optional restoring divide (1 bit per cycle).
module ddo_muldiv
(
    input  logic             clk,
    input  logic             rst_n,
    input  ddo_pkg::md_ctrl_t ctrl,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    input  logic [63:0]      d,
    output logic             done,
    output logic [63:0]      result
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_CHK  = 2'd2;
    localparam logic [1:0] P_DIV  = 2'd3;

    logic [1:0]  phase_reg;
    logic [5:0]  cnt_reg;
    logic        div_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] d_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;

    logic [67:0] acc_next;
    logic [64:0] rs_next;
    logic        ge_next;
    logic [64:0] sub_next;

    assign acc_next = {4'b0, hi_reg} + (68'(a_reg) * 68'(b_reg[3:0]));
    assign rs_next  = {hi_reg, lo_reg[63]};
    assign ge_next  = rs_next >= {1'b0, d_reg};
    assign sub_next = rs_next - {1'b0, d_reg};

    assign done   = done_reg;
    assign result = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        a_reg     <= a;
                        b_reg     <= b;
                        d_reg     <= d;
                        hi_reg    <= '0;
                        lo_reg    <= '0;
                        div_reg   <= ctrl.divide;
                        cnt_reg   <= '0;
                        phase_reg <= P_MUL;
                    end
                end
                P_MUL:
                begin
                    hi_reg  <= acc_next[67:4];
                    lo_reg  <= {acc_next[3:0], lo_reg[63:4]};
                    b_reg   <= {4'b0, b_reg[63:4]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                    begin
                        cnt_reg <= '0;
                        if (div_reg)
                        begin
                            phase_reg <= P_CHK;
                        end
                        else
                        begin
                            phase_reg <= P_IDLE;
                            done_reg  <= 1'b1;
                        end
                    end
                end
                P_CHK:
                begin
                    if (hi_reg >= d_reg)
                    begin
                        lo_reg    <= '1;
                        phase_reg <= P_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    hi_reg  <= ge_next ? sub_next[63:0] : rs_next[63:0];
                    lo_reg  <= {lo_reg[62:0], ge_next};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        cnt_reg   <= '0;
                        phase_reg <= P_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/differential_drive_odometry_top.sv @@
// Top level of the differential drive wheel odometry block (arc-chord update).
//
// Usage:
//   Input channel (in_valid/in_ready): left_travel, right_travel, sample_time.
//   Output channel (out_valid/out_ready): pos_x, pos_y, heading, vel_x, vel_y,
//   turn_rate, stamp. One transfer out for each input whose sample_time is
//   later than that of the last input kept; stale inputs are taken and dropped.
//   Config channel (cfg_valid/cfg_ready): track_width, always ready; write it
//   only while the block is idle.
//   One item is worked on at a time. An accepted item reaches the output
//   register after a shared digit-serial multiply/divide unit runs 10 to 13
//   operations in sequence, with two or three CORDIC rotations. The next item is
//   taken once the block is back in idle; a stale item is dropped without leaving
//   the idle state.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, the finished next result waits inside.
//   Reset clears the pose, heading and last timestamp and sets track_width to
//   1.0 m.
module differential_drive_odometry_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] left_travel,
    input  logic [31:0] right_travel,
    input  logic [62:0] sample_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] pos_x,
    output logic [47:0] pos_y,
    output logic [31:0] heading,
    output logic [31:0] vel_x,
    output logic [31:0] vel_y,
    output logic [31:0] turn_rate,
    output logic [62:0] stamp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] track_width
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DMAG  = 5'd1;
    localparam logic [4:0] S_SX    = 5'd2;
    localparam logic [4:0] S_SX2   = 5'd3;
    localparam logic [4:0] S_SD6   = 5'd4;
    localparam logic [4:0] S_SD120 = 5'd5;
    localparam logic [4:0] S_SCOS  = 5'd6;
    localparam logic [4:0] S_SDIV  = 5'd7;
    localparam logic [4:0] S_CHORD = 5'd8;
    localparam logic [4:0] S_CMID  = 5'd9;
    localparam logic [4:0] S_MX    = 5'd10;
    localparam logic [4:0] S_MY    = 5'd11;
    localparam logic [4:0] S_CNEW  = 5'd12;
    localparam logic [4:0] S_VX1   = 5'd13;
    localparam logic [4:0] S_VX2   = 5'd14;
    localparam logic [4:0] S_VY1   = 5'd15;
    localparam logic [4:0] S_VY2   = 5'd16;
    localparam logic [4:0] S_RATE  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    logic [4:0]  state_reg;
    logic        busy_reg;
    logic [30:0] tw_reg;
    logic [62:0] last_time_reg;
    logic [62:0] dt_reg;
    logic        sum_neg_reg;
    logic [32:0] sum_mag_reg;
    logic        diff_neg_reg;
    logic [32:0] diff_mag_reg;
    logic [63:0] dmag_reg;
    logic [63:0] t1_reg;
    logic [63:0] t2_reg;
    logic [63:0] sinc_mag_reg;
    logic        sinc_neg_reg;
    logic [63:0] chord_mag_reg;
    logic        chord_neg_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic        flip_reg;
    logic [4:0]  step_reg;
    logic signed [33:0] c_reg;
    logic signed [33:0] s_reg;
    logic signed [47:0] x_acc_reg;
    logic signed [47:0] y_acc_reg;
    logic [31:0] yaw_reg;
    logic [31:0] vx_reg;
    logic [31:0] vy_reg;
    logic [31:0] rate_reg;

    logic        out_valid_reg;
    logic [47:0] pos_x_reg;
    logic [47:0] pos_y_reg;
    logic [31:0] heading_reg;
    logic [31:0] vel_x_reg;
    logic [31:0] vel_y_reg;
    logic [31:0] turn_rate_reg;
    logic [62:0] stamp_reg;

    // operand and control for the shared multiply/divide unit
    ddo_pkg::md_ctrl_t md_ctrl;
    logic [63:0] md_a;
    logic [63:0] md_b;
    logic [63:0] md_d;
    logic        md_done;
    logic [63:0] md_res;
    logic        md_state;

    logic signed [32:0] sum_in;
    logic signed [32:0] diff_in;
    logic [30:0] tw_eff;
    logic [63:0] hmag;
    logic [31:0] half;
    logic [31:0] dlow;
    logic [33:0] c_mag;
    logic [33:0] s_mag;

    logic [31:0] ang;
    logic [31:0] ang_adj;
    logic        flip_in;
    logic signed [33:0] xsh;
    logic signed [33:0] ysh;
    logic signed [33:0] atan_s;
    logic signed [33:0] cx_next;
    logic signed [33:0] cy_next;
    logic signed [33:0] cz_next;
    logic        cordic_state;
    logic [63:0] rate_q;

    function automatic logic [31:0] clamp32(input logic neg, input logic [63:0] m);
        logic [63:0] nm;
        nm = ~m + 64'd1;
        if (neg)
        begin
            return (m > 64'h8000_0000) ? 32'h8000_0000 : nm[31:0];
        end
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [47:0] acc,
                                                   input logic [33:0] m,
                                                   input logic neg);
        logic signed [49:0] delta;
        logic signed [49:0] total;
        delta = $signed({16'b0, m});
        if (neg)
        begin
            delta = -delta;
        end
        total = 50'(acc) + delta;
        if (total > 50'sh0_7FFF_FFFF_FFFF)
        begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (total < -50'sh0_8000_0000_0000)
        begin
            return 48'sh8000_0000_0000;
        end
        return total[47:0];
    endfunction

    assign sum_in  = $signed({left_travel[31], left_travel})
                   + $signed({right_travel[31], right_travel});
    assign diff_in = $signed({right_travel[31], right_travel})
                   - $signed({left_travel[31], left_travel});
    assign tw_eff  = (tw_reg == '0) ? 31'd1 : tw_reg;
    assign hmag    = {1'b0, dmag_reg[63:1]};
    assign half    = diff_neg_reg ? (32'd0 - hmag[31:0]) : hmag[31:0];
    assign dlow    = diff_neg_reg ? (32'd0 - dmag_reg[31:0]) : dmag_reg[31:0];
    assign c_mag   = c_reg[33] ? 34'(-c_reg) : 34'(c_reg);
    assign s_mag   = s_reg[33] ? 34'(-s_reg) : 34'(s_reg);
    assign rate_q  = (md_res == '1) ? md_res : (md_res >> ddo_pkg::RATE_SHIFT);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign turn_rate = turn_rate_reg;
    assign stamp     = stamp_reg;

    // unit operands per step
    always_comb
    begin
        md_a = '0;
        md_b = '0;
        md_d = 64'd1;
        md_ctrl.divide = 1'b0;
        md_state = 1'b1;
        unique case (state_reg)
            S_DMAG:
            begin
                md_a = 64'(diff_mag_reg);
                md_b = ddo_pkg::BAM_PER_RAD_Q48;
                md_d = 64'({tw_eff, 16'b0});
                md_ctrl.divide = 1'b1;
            end
            S_SX:
            begin
                md_a = hmag;
                md_b = ddo_pkg::TWO_PI_Q29;
            end
            S_SX2:
            begin
                md_a = t1_reg;
                md_b = t1_reg;
            end
            S_SD6:
            begin
                md_a = t1_reg;
                md_b = 64'd1;
                md_d = ddo_pkg::DIV_BY_SIX;
                md_ctrl.divide = 1'b1;
            end
            S_SD120:
            begin
                md_a = t1_reg;
                md_b = t1_reg;
                md_d = ddo_pkg::DIV_BY_120;
                md_ctrl.divide = 1'b1;
            end
            S_SDIV:
            begin
                md_a = 64'(s_mag);
                md_b = ddo_pkg::BAM_PER_RAD_Q48;
                md_d = hmag;
                md_ctrl.divide = 1'b1;
            end
            S_CHORD:
            begin
                md_a = 64'(sum_mag_reg);
                md_b = sinc_mag_reg;
            end
            S_MX:
            begin
                md_a = chord_mag_reg;
                md_b = 64'(c_mag);
            end
            S_MY:
            begin
                md_a = chord_mag_reg;
                md_b = 64'(s_mag);
            end
            S_VX1:
            begin
                md_a = 64'(sum_mag_reg);
                md_b = 64'(c_mag);
            end
            S_VY1:
            begin
                md_a = 64'(sum_mag_reg);
                md_b = 64'(s_mag);
            end
            S_VX2, S_VY2:
            begin
                md_a = t1_reg;
                md_b = ddo_pkg::NS_PER_S;
                md_d = 64'(dt_reg);
                md_ctrl.divide = 1'b1;
            end
            S_RATE:
            begin
                md_a = dmag_reg;
                md_b = ddo_pkg::RATE_SCALE;
                md_d = 64'(dt_reg);
                md_ctrl.divide = 1'b1;
            end
            default:
            begin
                md_state = 1'b0;
            end
        endcase
        md_ctrl.start = md_state && !busy_reg;
    end

    // CORDIC rotation, one step per cycle
    always_comb
    begin
        cordic_state = 1'b1;
        unique case (state_reg)
            S_SCOS: ang = hmag[31:0];
            S_CMID: ang = yaw_reg + half;
            S_CNEW: ang = yaw_reg;
            default:
            begin
                ang = yaw_reg;
                cordic_state = 1'b0;
            end
        endcase
    end

    assign flip_in = ang[31] ^ ang[30];
    assign ang_adj = flip_in ? (ang - 32'h8000_0000) : ang;
    assign xsh     = cx_reg >>> step_reg;
    assign ysh     = cy_reg >>> step_reg;
    assign atan_s  = $signed({2'b0, ddo_pkg::atan_bam(step_reg)});

    always_comb
    begin
        if (!cz_reg[33])
        begin
            cx_next = cx_reg - ysh;
            cy_next = cy_reg + xsh;
            cz_next = cz_reg - atan_s;
        end
        else
        begin
            cx_next = cx_reg + ysh;
            cy_next = cy_reg - xsh;
            cz_next = cz_reg + atan_s;
        end
    end

    ddo_muldiv u_muldiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .a      (md_a),
        .b      (md_b),
        .d      (md_d),
        .done   (md_done),
        .result (md_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            tw_reg        <= 31'(1 << ddo_pkg::FRACTION_BITS);
            last_time_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tw_reg <= track_width;
            end

            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            if (md_ctrl.start)
            begin
                busy_reg <= 1'b1;
            end

            if (cordic_state)
            begin
                if (!busy_reg)
                begin
                    busy_reg <= 1'b1;
                    cx_reg   <= ddo_pkg::CORDIC_GAIN;
                    cy_reg   <= '0;
                    cz_reg   <= $signed({{2{ang_adj[31]}}, ang_adj});
                    flip_reg <= flip_in;
                    step_reg <= '0;
                end
                else
                begin
                    cx_reg   <= cx_next;
                    cy_reg   <= cy_next;
                    cz_reg   <= cz_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(ddo_pkg::CORDIC_STEPS - 1))
                    begin
                        busy_reg <= 1'b0;
                        c_reg    <= flip_reg ? -cx_next : cx_next;
                        s_reg    <= flip_reg ? -cy_next : cy_next;
                        unique case (state_reg)
                            S_SCOS:  state_reg <= S_SDIV;
                            S_CMID:  state_reg <= S_MX;
                            default: state_reg <= S_VX1;
                        endcase
                    end
                end
            end

            if (md_done)
            begin
                busy_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (sample_time > last_time_reg))
                    begin
                        dt_reg        <= sample_time - last_time_reg;
                        last_time_reg <= sample_time;
                        sum_neg_reg   <= sum_in[32];
                        sum_mag_reg   <= sum_in[32] ? 33'(-sum_in) : 33'(sum_in);
                        diff_neg_reg  <= diff_in[32];
                        diff_mag_reg  <= diff_in[32] ? 33'(-diff_in) : 33'(diff_in);
                        state_reg     <= S_DMAG;
                    end
                end
                S_DMAG:
                begin
                    if (md_done)
                    begin
                        dmag_reg  <= md_res;
                        state_reg <= ({1'b0, md_res[63:1]} < ddo_pkg::SINC_LIMIT) ?
                                     S_SX : S_SCOS;
                    end
                end
                S_SX:
                begin
                    if (md_done)
                    begin
                        t1_reg    <= md_res >> 29;
                        state_reg <= S_SX2;
                    end
                end
                S_SX2:
                begin
                    if (md_done)
                    begin
                        t1_reg    <= md_res >> 32;
                        state_reg <= S_SD6;
                    end
                end
                S_SD6:
                begin
                    if (md_done)
                    begin
                        t2_reg    <= md_res;
                        state_reg <= S_SD120;
                    end
                end
                S_SD120:
                begin
                    if (md_done)
                    begin
                        sinc_mag_reg <= (ddo_pkg::SINC_ONE_Q32 - t2_reg + (md_res >> 32)) >> 2;
                        sinc_neg_reg <= 1'b0;
                        state_reg    <= S_CHORD;
                    end
                end
                S_SDIV:
                begin
                    if (md_done)
                    begin
                        sinc_mag_reg <= md_res >> ddo_pkg::BAM_SHIFT;
                        sinc_neg_reg <= s_reg[33];
                        state_reg    <= S_CHORD;
                    end
                end
                S_CHORD:
                begin
                    if (md_done)
                    begin
                        chord_mag_reg <= md_res >> 31;
                        chord_neg_reg <= sum_neg_reg ^ sinc_neg_reg;
                        state_reg     <= S_CMID;
                    end
                end
                S_MX:
                begin
                    if (md_done)
                    begin
                        x_acc_reg <= clamp48(x_acc_reg, md_res[63:30], chord_neg_reg ^ c_reg[33]);
                        state_reg <= S_MY;
                    end
                end
                S_MY:
                begin
                    if (md_done)
                    begin
                        y_acc_reg <= clamp48(y_acc_reg, md_res[63:30], chord_neg_reg ^ s_reg[33]);
                        yaw_reg   <= yaw_reg + dlow;
                        state_reg <= S_CNEW;
                    end
                end
                S_VX1:
                begin
                    if (md_done)
                    begin
                        t1_reg    <= md_res;
                        state_reg <= S_VX2;
                    end
                end
                S_VX2:
                begin
                    if (md_done)
                    begin
                        vx_reg    <= clamp32(sum_neg_reg ^ c_reg[33], md_res >> 31);
                        state_reg <= S_VY1;
                    end
                end
                S_VY1:
                begin
                    if (md_done)
                    begin
                        t1_reg    <= md_res;
                        state_reg <= S_VY2;
                    end
                end
                S_VY2:
                begin
                    if (md_done)
                    begin
                        vy_reg    <= clamp32(sum_neg_reg ^ s_reg[33], md_res >> 31);
                        state_reg <= S_RATE;
                    end
                end
                S_RATE:
                begin
                    if (md_done)
                    begin
                        rate_reg  <= clamp32(diff_neg_reg, rate_q);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_x_reg     <= x_acc_reg;
                        pos_y_reg     <= y_acc_reg;
                        heading_reg   <= yaw_reg;
                        vel_x_reg     <= vx_reg;
                        vel_y_reg     <= vy_reg;
                        turn_rate_reg <= rate_reg;
                        stamp_reg     <= last_time_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ tb/tb_differential_drive_odometry_top.sv @@
// Testbench for differential_drive_odometry_top: a self-checking pose, velocity and yaw-rate predictor.
`timescale 1ns / 100ps

module tb_differential_drive_odometry_top;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
        logic [62:0] t;
    } sample_t;

    typedef struct {
        logic [47:0] px;
        logic [47:0] py;
        logic [31:0] hdg;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] rate;
        logic [62:0] t;
    } pose_t;

    localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint POS_LIM = 64'sh7FFF_FFFF_FFFF;
    localparam logic [31:0] ARCTAN [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] left_travel;
    logic [31:0] right_travel;
    logic [62:0] sample_time;
    logic        out_valid;
    logic        out_ready;
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] turn_rate;
    logic [62:0] stamp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] track_width;

    differential_drive_odometry_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_travel  (left_travel),
        .right_travel (right_travel),
        .sample_time  (sample_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .turn_rate    (turn_rate),
        .stamp        (stamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .track_width  (track_width)
    );

    // odometry state mirrored by the predictor
    logic [62:0] odo_last_t;
    longint      odo_x;
    longint      odo_y;
    logic [31:0] odo_yaw;
    logic [30:0] odo_track;

    sample_t samples_pending[$];
    pose_t   poses_expected[$];
    int      errors;
    int      poses_seen;
    bit      no_idle;
    bit      in_fire;
    bit      out_fire;
    int      in_gap;
    int      out_stall;
    int      long_hold;
    bit      long_hold_done;
    logic [62:0] gen_time;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    // floor(a*b/d), saturating to all ones
    function automatic longint unsigned scaled_ratio(input longint unsigned a,
                                                     input longint unsigned b,
                                                     input longint unsigned d);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p / {64'd0, d};
        return q[127:64] != 0 ? ALL_ONES : q[63:0];
    endfunction

    function automatic longint trunc_product(input longint a, input longint b, input int n);
        longint unsigned p;
        p = (mag(a) * mag(b)) >> n;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint c,
                                   output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        logic [31:0] probe;
        bit flip;
        x = longint'(ddo_pkg::CORDIC_GAIN);
        y = 0;
        probe = ang + 32'h40000000;
        flip = probe[31];
        if (flip)
            ang = ang - 32'h80000000;
        z = longint'($signed(ang));
        for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ARCTAN[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ARCTAN[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint sinc_q30(input longint unsigned hmag);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s32;
        longint unsigned q;
        longint c;
        longint s;
        if (hmag < ddo_pkg::SINC_LIMIT)
        begin
            x = (hmag * ddo_pkg::TWO_PI_Q29) >> 29;
            x2 = (x * x) >> 32;
            s32 = ddo_pkg::SINC_ONE_Q32 - x2 / 6 + ((x2 * x2) >> 32) / 120;
            return longint'(s32 >> 2);
        end
        rotate(hmag[31:0], c, s);
        q = scaled_ratio(mag(s), ddo_pkg::BAM_PER_RAD_Q48, hmag) >> ddo_pkg::BAM_SHIFT;
        return s < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] sat32(input bit neg, input longint unsigned m);
        if (neg)
            return m > 64'h80000000 ? 32'h80000000 : 32'd0 - m[31:0];
        return m > 64'h7FFFFFFF ? 32'h7FFFFFFF : m[31:0];
    endfunction

    function automatic longint sat48(input longint v);
        return v > POS_LIM ? POS_LIM : (v < -POS_LIM - 1 ? -POS_LIM - 1 : v);
    endfunction

    function automatic logic [31:0] speed_part(input longint sum, input longint trig,
                                               input longint unsigned dt);
        longint unsigned q;
        q = scaled_ratio(mag(sum) * mag(trig), ddo_pkg::NS_PER_S, dt) >> 31;
        return sat32((sum < 0) != (trig < 0), q);
    endfunction

    task automatic advance_pose(input sample_t smp);
        longint sum;
        longint diff;
        longint chord;
        longint c;
        longint s;
        longint unsigned dt;
        longint unsigned tw;
        longint unsigned dmag;
        longint unsigned hmag;
        longint unsigned q;
        logic [31:0] half;
        logic [31:0] dlow;
        pose_t p;
        if (smp.t <= odo_last_t)
            return;
        dt = 64'(smp.t - odo_last_t);
        sum = longint'($signed(smp.left)) + longint'($signed(smp.right));
        diff = longint'($signed(smp.right)) - longint'($signed(smp.left));
        tw = odo_track != 0 ? 64'(odo_track) : 64'd1;
        dmag = scaled_ratio(mag(diff), ddo_pkg::BAM_PER_RAD_Q48, tw << ddo_pkg::BAM_SHIFT);
        hmag = dmag >> 1;
        half = hmag[31:0];
        dlow = dmag[31:0];
        if (diff < 0)
        begin
            half = 32'd0 - half;
            dlow = 32'd0 - dlow;
        end
        chord = trunc_product(sum, sinc_q30(hmag), 31);
        rotate(odo_yaw + half, c, s);
        odo_x = sat48(odo_x + trunc_product(chord, c, 30));
        odo_y = sat48(odo_y + trunc_product(chord, s, 30));
        odo_yaw = odo_yaw + dlow;
        odo_last_t = smp.t;
        rotate(odo_yaw, c, s);
        p.vx = speed_part(sum, c, dt);
        p.vy = speed_part(sum, s, dt);
        q = scaled_ratio(dmag, ddo_pkg::RATE_SCALE, dt);
        if (q != ALL_ONES)
            q = q >> ddo_pkg::RATE_SHIFT;
        p.rate = sat32(diff < 0, q);
        p.px = odo_x[47:0];
        p.py = odo_y[47:0];
        p.hdg = odo_yaw;
        p.t = smp.t;
        poses_expected.push_back(p);
    endtask

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch on %s: got %h expected %h", field, got, want);
    endtask

    // input driver
    always @(posedge clk)
    begin
        in_fire = in_valid && in_ready;
        if (in_fire)
            advance_pose('{left_travel, right_travel, sample_time});
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (samples_pending.size() > 0)
            begin
                left_travel  <= samples_pending[0].left;
                right_travel <= samples_pending[0].right;
                sample_time  <= samples_pending[0].t;
                void'(samples_pending.pop_front());
                in_valid <= 1'b1;
                in_gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        out_fire = out_valid && out_ready;
        if (out_fire)
        begin
            poses_seen++;
            if (poses_expected.size() == 0)
                report("unexpected transfer, stamp", 64'(stamp), 64'd0);
            else
            begin
                if (pos_x !== poses_expected[0].px)
                    report("pos_x", pos_x, poses_expected[0].px);
                if (pos_y !== poses_expected[0].py)
                    report("pos_y", pos_y, poses_expected[0].py);
                if (heading !== poses_expected[0].hdg)
                    report("heading", heading, poses_expected[0].hdg);
                if (vel_x !== poses_expected[0].vx)
                    report("vel_x", vel_x, poses_expected[0].vx);
                if (vel_y !== poses_expected[0].vy)
                    report("vel_y", vel_y, poses_expected[0].vy);
                if (turn_rate !== poses_expected[0].rate)
                    report("turn_rate", turn_rate, poses_expected[0].rate);
                if (stamp !== poses_expected[0].t)
                    report("stamp", stamp, poses_expected[0].t);
                void'(poses_expected.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!long_hold_done && poses_seen == 100)
        begin
            long_hold_done = 1'b1;
            long_hold = 4000;
        end
        if (out_fire)
            out_stall = no_idle ? 0 : $urandom_range(0, 6);
        if (long_hold > 0)
        begin
            long_hold--;
            out_ready <= 1'b0;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic [31:0] rand_travel(input int kind);
        case (kind)
            0: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            1: return $urandom;
            default: return $urandom_range(0, 32'h0000_0800) - 32'h0000_0400;
        endcase
    endfunction

    task automatic queue_sample(input logic [31:0] l, input logic [31:0] r,
                                input logic [62:0] t);
        samples_pending.push_back('{l, r, t});
    endtask

    task automatic queue_random(input int count);
        logic [31:0] l;
        logic [31:0] r;
        logic [62:0] t;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                l = rand_travel(0);
                r = rand_travel(0);
            end
            else if (pick < 75)
            begin
                l = rand_travel(1);
                r = rand_travel(1);
            end
            else
            begin
                l = rand_travel(1);
                r = l + rand_travel(2);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                t = gen_time >= 3 ? gen_time - 63'($urandom_range(0, 3)) : gen_time;
            else
            begin
                if (pick < 9)
                    t = gen_time + 63'({$urandom, $urandom} >> 6);
                else if (pick < 20)
                    t = gen_time + 63'($urandom_range(1, 10));
                else
                    t = gen_time + 63'($urandom_range(1000, 20000000));
                gen_time = t;
            end
            queue_sample(l, r, t);
        end
    endtask

    task automatic drain;
        while (samples_pending.size() > 0 || in_valid || poses_expected.size() > 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_track(input logic [30:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        track_width <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        odo_track = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        left_travel = '0;
        right_travel = '0;
        sample_time = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        track_width = '0;
        odo_last_t = '0;
        odo_x = 0;
        odo_y = 0;
        odo_yaw = '0;
        odo_track = 31'd65536;
        errors = 0;
        poses_seen = 0;
        no_idle = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        in_gap = 0;
        out_stall = 0;
        long_hold = 0;
        long_hold_done = 1'b0;
        gen_time = 63'd1000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero, straight, reverse, spin, extremes, stale, tiny dt
        queue_sample(32'd0, 32'd0, 63'd1000);
        queue_sample(32'h0001_0000, 32'h0001_0000, 63'd2000);
        queue_sample(32'hFFFF_0000, 32'hFFFF_0000, 63'd3000);
        queue_sample(32'hFFFF_0000, 32'h0001_0000, 63'd4000);
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd5000);
        queue_sample(32'h8000_0000, 32'h8000_0000, 63'd6000);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 63'd7000);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 63'd8000);
        queue_sample(32'd0, 32'h7FFF_FFFF, 63'd9000);
        queue_sample(32'h0001_0000, 32'h0002_0000, 63'd9000);
        queue_sample(32'h0001_0000, 32'h0002_0000, 63'd8500);
        queue_sample(32'h7000_0000, 32'h6000_0000, 63'd9001);
        queue_sample(32'hFFFF_8000, 32'hFFFF_0000, 63'd10000001);
        gen_time = 63'd10000001;
        queue_random(300);
        drain();

        write_track(31'd1);
        queue_random(300);
        drain();

        write_track(31'h7FFF_FFFF);
        queue_random(300);
        drain();

        write_track(31'd0);
        queue_random(250);
        drain();

        write_track(31'd32768);
        no_idle = 1'b1;
        queue_random(250);
        drain();
        no_idle = 1'b0;

        write_track(31'($urandom_range(1, 32'h7FFF_FFFF)));
        queue_random(530);
        queue_sample(32'h0003_0000, 32'h0001_0000, 63'h7FFF_FFFF_FFFF_FFFF);
        drain();

        if (errors == 0)
            $display("** differential_drive_odometry_top: PASSED **");
        else
            $display("** differential_drive_odometry_top: FAILED **");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("** differential_drive_odometry_top: FAILED **");
        $finish;
    end

endmodule
